@@ rtl/core/ted_pkg.sv @@
// Types, constants and helper functions for the text encoding detector.
// No dependencies; every other file of the block but the two interfaces refers to it by scoped names.
package ted_pkg;

  // Candidate bits of the alive vector, in priority order
  localparam int unsigned CandAscii = 0;
  localparam int unsigned CandU8Bom = 1;
  localparam int unsigned CandU8    = 2;
  localparam int unsigned CandU16Be = 3;
  localparam int unsigned CandU16Le = 4;
  localparam int unsigned CandIso   = 5;
  localparam int unsigned CandExt   = 6;
  localparam int unsigned NumCand   = 7;

  // Result codes
  localparam logic [2:0] EncAscii   = 3'd0;
  localparam logic [2:0] EncU8Bom   = 3'd1;
  localparam logic [2:0] EncU8      = 3'd2;
  localparam logic [2:0] EncU16Be   = 3'd3;
  localparam logic [2:0] EncU16Le   = 3'd4;
  localparam logic [2:0] EncIso     = 3'd5;
  localparam logic [2:0] EncExt     = 3'd6;
  localparam logic [2:0] EncUnknown = 3'd7;

  localparam logic [7:0] Bom8Byte0 = 8'hef;
  localparam logic [7:0] Bom8Byte1 = 8'hbb;
  localparam logic [7:0] Bom8Byte2 = 8'hbf;
  localparam logic [7:0] Bom16Fe   = 8'hfe;
  localparam logic [7:0] Bom16Ff   = 8'hff;

  typedef struct packed {
    logic [NumCand-1:0] alive;
    logic [1:0]         byte_pos;   // saturates at three
    logic               odd_pos;
    logic [7:0]         held_byte;
    logic [2:0]         cont_pend;
    logic               mb_seen;
  } state_t;

  localparam state_t StateReset = '{
    alive:     {NumCand{1'b1}},
    byte_pos:  2'd0,
    odd_pos:   1'b0,
    held_byte: 8'h00,
    cont_pend: 3'd0,
    mb_seen:   1'b0
  };

  function automatic logic is_text(input logic [7:0] b);
    logic r;
    r = ((b >= 8'h07) && (b <= 8'h0a)) || (b == 8'h0c) || (b == 8'h0d) ||
        (b == 8'h1b) || (b == 8'h85) || ((b >= 8'h20) && (b <= 8'h7e));
    return r;
  endfunction

  // Continuation bytes that follow a lead byte 11xxxxxx; zero means illegal lead
  function automatic logic [2:0] lead_follow(input logic [7:0] b);
    logic [2:0] f;
    if (!b[5])      f = 3'd1;
    else if (!b[4]) f = 3'd2;
    else if (!b[3]) f = 3'd3;
    else if (!b[2]) f = 3'd4;
    else if (!b[1]) f = 3'd5;
    else            f = 3'd0;
    return f;
  endfunction

  function automatic logic [7:0] bom8_byte(input logic [1:0] pos);
    logic [7:0] v;
    unique case (pos)
      2'd0:    v = Bom8Byte0;
      2'd1:    v = Bom8Byte1;
      default: v = Bom8Byte2;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/ted_in_if.sv @@
// Input byte channel of the text encoding detector.
// Depends on nothing; valid/ready handshake, one byte per beat.
interface ted_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ rtl/core/ted_out_if.sv @@
// Result channel of the text encoding detector.
// Depends on nothing; valid/ready handshake, one encoding index per beat.
interface ted_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] encoding_index;

  modport source (output valid, output encoding_index, input ready);
  modport sink   (input valid, input encoding_index, output ready);
endinterface

@@ rtl/core/ted_byte_eval.sv @@
// Per-byte evaluation: next detector state and, on the last byte, the verdict.
// Depends on ted_pkg.
module ted_byte_eval (
  input  ted_pkg::state_t state_i,
  input  logic [7:0]      data_byte_i,
  input  logic            last_byte_i,
  output ted_pkg::state_t state_o,
  output logic [2:0]      encoding_index_o
);

  ted_pkg::state_t            nxt;
  logic [ted_pkg::NumCand-1:0] fin;
  logic                        text;
  logic [2:0]                  follow;

  always_comb begin
    nxt    = state_i;
    text   = ted_pkg::is_text(data_byte_i);
    follow = ted_pkg::lead_follow(data_byte_i);

    if (!text) nxt.alive[ted_pkg::CandAscii] = 1'b0;
    if (!(text || data_byte_i >= 8'ha0)) nxt.alive[ted_pkg::CandIso] = 1'b0;
    if (!(text || data_byte_i[7])) nxt.alive[ted_pkg::CandExt] = 1'b0;

    if (state_i.byte_pos != 2'd3 && data_byte_i != ted_pkg::bom8_byte(state_i.byte_pos))
      nxt.alive[ted_pkg::CandU8Bom] = 1'b0;

    // UTF-8 sequence tracking
    if (state_i.cont_pend != 3'd0) begin
      if (data_byte_i[7:6] != 2'b10) begin
        nxt.alive[ted_pkg::CandU8] = 1'b0;
        nxt.cont_pend = 3'd0;
      end else begin
        nxt.cont_pend = state_i.cont_pend - 3'd1;
        if (state_i.cont_pend == 3'd1) nxt.mb_seen = 1'b1;
      end
    end else if (!data_byte_i[7]) begin
      if (!text) nxt.alive[ted_pkg::CandU8] = 1'b0;
    end else if (!data_byte_i[6]) begin
      nxt.alive[ted_pkg::CandU8] = 1'b0;
    end else begin
      if (follow == 3'd0) nxt.alive[ted_pkg::CandU8] = 1'b0;
      nxt.cont_pend = follow;
    end

    // UTF-16 code units
    if (!state_i.odd_pos) begin
      if (state_i.byte_pos == 2'd0) begin
        if (data_byte_i != ted_pkg::Bom16Fe) nxt.alive[ted_pkg::CandU16Be] = 1'b0;
        if (data_byte_i != ted_pkg::Bom16Ff) nxt.alive[ted_pkg::CandU16Le] = 1'b0;
      end
      nxt.held_byte = data_byte_i;
    end else begin
      if (state_i.byte_pos == 2'd1) begin
        if (data_byte_i != ted_pkg::Bom16Ff) nxt.alive[ted_pkg::CandU16Be] = 1'b0;
        if (data_byte_i != ted_pkg::Bom16Fe) nxt.alive[ted_pkg::CandU16Le] = 1'b0;
      end
      // unit FFFE, or a unit below 128 that is not text
      if ((state_i.held_byte == 8'hff && data_byte_i == 8'hfe) ||
          (state_i.held_byte == 8'h00 && !data_byte_i[7] && !text))
        nxt.alive[ted_pkg::CandU16Be] = 1'b0;
      if ((data_byte_i == 8'hff && state_i.held_byte == 8'hfe) ||
          (data_byte_i == 8'h00 && !state_i.held_byte[7] &&
           !ted_pkg::is_text(state_i.held_byte)))
        nxt.alive[ted_pkg::CandU16Le] = 1'b0;
    end

    nxt.odd_pos = ~state_i.odd_pos;
    if (state_i.byte_pos != 2'd3) nxt.byte_pos = state_i.byte_pos + 2'd1;

    // verdict for a stream ending on this byte
    fin = nxt.alive;
    if (!nxt.mb_seen) begin
      fin[ted_pkg::CandU8]    = 1'b0;
      fin[ted_pkg::CandU8Bom] = 1'b0;
    end
    if (!fin[ted_pkg::CandU8] || state_i.byte_pos < 2'd2) fin[ted_pkg::CandU8Bom] = 1'b0;
    if (!state_i.odd_pos) begin
      fin[ted_pkg::CandU16Be] = 1'b0;
      fin[ted_pkg::CandU16Le] = 1'b0;
    end

    if (fin[ted_pkg::CandAscii])      encoding_index_o = ted_pkg::EncAscii;
    else if (fin[ted_pkg::CandU8Bom]) encoding_index_o = ted_pkg::EncU8Bom;
    else if (fin[ted_pkg::CandU8])    encoding_index_o = ted_pkg::EncU8;
    else if (fin[ted_pkg::CandU16Be]) encoding_index_o = ted_pkg::EncU16Be;
    else if (fin[ted_pkg::CandU16Le]) encoding_index_o = ted_pkg::EncU16Le;
    else if (fin[ted_pkg::CandIso])   encoding_index_o = ted_pkg::EncIso;
    else if (fin[ted_pkg::CandExt])   encoding_index_o = ted_pkg::EncExt;
    else                              encoding_index_o = ted_pkg::EncUnknown;

    state_o = last_byte_i ? ted_pkg::StateReset : nxt;
  end

endmodule

@@ rtl/core/text_encoding_detector.sv @@
// Text encoding detector top level: state register, evaluator and result register.
// Depends on ted_pkg, ted_in_if, ted_out_if and ted_byte_eval.
//
// Takes one byte per beat and, on the beat marked last_byte, delivers one
// encoding_index beat: the first of ASCII, UTF-8 with BOM, UTF-8, UTF-16BE,
// UTF-16LE, ISO-8859, extended ASCII that fits the whole stream, else Unknown.
// The detector state is cleared after the last byte, so the next stream can
// start on the following beat. A byte is taken every cycle while the input is
// not stalled; the evaluation of a byte against the running state is
// combinational logic, and the result sits in an output register. The input
// stalls only while a finished result is held and the sink does not take it in that same cycle.
module text_encoding_detector (
  input  logic      clk_i,
  input  logic      rst_ni,
  ted_in_if.sink    in_i,
  ted_out_if.source out_o
);

  ted_pkg::state_t state_q, state_d;
  logic [2:0]      enc_idx;
  logic [2:0]      enc_idx_q;
  logic            out_valid_q;
  logic            in_beat;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_beat    = in_i.valid && in_i.ready;

  ted_byte_eval u_eval (
    .state_i          (state_q),
    .data_byte_i      (in_i.data_byte),
    .last_byte_i      (in_i.last_byte),
    .state_o          (state_d),
    .encoding_index_o (enc_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ted_pkg::StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (in_beat) state_q <= state_d;
      if (in_beat && in_i.last_byte) out_valid_q <= 1'b1;
      else if (out_o.ready)          out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat && in_i.last_byte) enc_idx_q <= enc_idx;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.encoding_index = enc_idx_q;

endmodule

@@ verif/ted_stream_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the text encoding detector: follows every byte beat, predicts the
// encoding reported on the last byte of each stream and compares the result beats.
// Depends on ted_pkg for candidate bit positions, encoding codes and BOM bytes.
module ted_stream_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [2:0] out_enc_i,
  output int         error_count_o,
  output int         pending_o,
  output int         results_o,
  output logic [7:0] enc_hit_o
);

  // per-stream detection state
  logic [ted_pkg::NumCand-1:0] live_q;
  logic [1:0]                  pos_q;       // saturates at three
  logic                        odd_q;       // next byte closes a 16-bit unit
  logic [7:0]                  unit_first_q;
  logic [2:0]                  cont_left_q;
  logic                        mb_done_q;

  logic [2:0] enc_expected_q[$];
  int         errors;
  int         results;
  logic [7:0] hits;

  function automatic logic text_byte(input logic [7:0] b);
    logic t;
    case (b)
      8'h07, 8'h08, 8'h09, 8'h0a, 8'h0c, 8'h0d, 8'h1b, 8'h85: t = 1'b1;
      default: t = (b >= 8'h20) && (b < 8'h7f);
    endcase
    return t;
  endfunction

  // continuation bytes owed after a 11xxxxxx lead; zero for an illegal lead
  function automatic logic [2:0] tail_len(input logic [7:0] b);
    logic [2:0] n;
    casez (b)
      8'b110?????: n = 3'd1;
      8'b1110????: n = 3'd2;
      8'b11110???: n = 3'd3;
      8'b111110??: n = 3'd4;
      8'b1111110?: n = 3'd5;
      default:     n = 3'd0;
    endcase
    return n;
  endfunction

  task automatic clear_stream();
    live_q       = '1;
    pos_q        = 2'd0;
    odd_q        = 1'b0;
    unit_first_q = 8'h00;
    cont_left_q  = 3'd0;
    mb_done_q    = 1'b0;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic last);
    logic [ted_pkg::NumCand-1:0] live;
    logic [ted_pkg::NumCand-1:0] fin;
    logic                        txt;
    logic                        was_odd;
    logic [1:0]                  pos;
    logic [7:0]                  bom_byte;
    logic [15:0]                 unit_be;
    logic [15:0]                 unit_le;
    logic [2:0]                  enc;
    int                          k;
    live    = live_q;
    pos     = pos_q;
    was_odd = odd_q;
    txt     = text_byte(b);

    if (!txt) live[ted_pkg::CandAscii] = 1'b0;
    if (!txt && b < 8'ha0) live[ted_pkg::CandIso] = 1'b0;
    if (!txt && !b[7]) live[ted_pkg::CandExt] = 1'b0;

    case (pos)
      2'd0:    bom_byte = ted_pkg::Bom8Byte0;
      2'd1:    bom_byte = ted_pkg::Bom8Byte1;
      default: bom_byte = ted_pkg::Bom8Byte2;
    endcase
    if (pos != 2'd3 && b != bom_byte) live[ted_pkg::CandU8Bom] = 1'b0;

    if (cont_left_q != 3'd0) begin
      if (b[7:6] != 2'b10) begin
        live[ted_pkg::CandU8] = 1'b0;
        cont_left_q           = 3'd0;
      end else begin
        cont_left_q = cont_left_q - 3'd1;
        if (cont_left_q == 3'd0) mb_done_q = 1'b1;
      end
    end else if (!b[7]) begin
      if (!txt) live[ted_pkg::CandU8] = 1'b0;
    end else if (!b[6]) begin
      live[ted_pkg::CandU8] = 1'b0;
    end else begin
      cont_left_q = tail_len(b);
      if (cont_left_q == 3'd0) live[ted_pkg::CandU8] = 1'b0;
    end

    if (!was_odd) begin
      if (pos == 2'd0) begin
        if (b != ted_pkg::Bom16Fe) live[ted_pkg::CandU16Be] = 1'b0;
        if (b != ted_pkg::Bom16Ff) live[ted_pkg::CandU16Le] = 1'b0;
      end
      unit_first_q = b;
    end else begin
      unit_be = {unit_first_q, b};
      unit_le = {b, unit_first_q};
      if (pos == 2'd1) begin
        if (b != ted_pkg::Bom16Ff) live[ted_pkg::CandU16Be] = 1'b0;
        if (b != ted_pkg::Bom16Fe) live[ted_pkg::CandU16Le] = 1'b0;
      end
      if (unit_be == 16'hfffe || (unit_be < 16'd128 && !text_byte(unit_be[7:0])))
        live[ted_pkg::CandU16Be] = 1'b0;
      if (unit_le == 16'hfffe || (unit_le < 16'd128 && !text_byte(unit_le[7:0])))
        live[ted_pkg::CandU16Le] = 1'b0;
    end

    odd_q  = !was_odd;
    if (pos != 2'd3) pos_q = pos + 2'd1;
    live_q = live;

    if (last) begin
      fin = live;
      if (!mb_done_q) begin
        fin[ted_pkg::CandU8]    = 1'b0;
        fin[ted_pkg::CandU8Bom] = 1'b0;
      end
      if (!fin[ted_pkg::CandU8] || pos < 2'd2) fin[ted_pkg::CandU8Bom] = 1'b0;
      // odd byte count rules out both UTF-16 flavors
      if (!was_odd) begin
        fin[ted_pkg::CandU16Be] = 1'b0;
        fin[ted_pkg::CandU16Le] = 1'b0;
      end
      enc = ted_pkg::EncUnknown;
      for (k = ted_pkg::NumCand - 1; k >= 0; k--) begin
        if (fin[k]) enc = 3'(k);
      end
      enc_expected_q.push_back(enc);
      hits[enc] = 1'b1;
      clear_stream();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    logic [2:0] enc;
    if (!rst_ni) begin
      clear_stream();
      enc_expected_q.delete();
      errors        = 0;
      results       = 0;
      hits          = 8'h00;
      error_count_o <= 0;
      pending_o     <= 0;
      results_o     <= 0;
      enc_hit_o     <= 8'h00;
    end else begin
      if (in_valid_i && in_ready_i) absorb_byte(in_byte_i, in_last_i);
      if (out_valid_i && out_ready_i) begin
        if (enc_expected_q.size() == 0) begin
          errors++;
          $error("unexpected result beat: encoding_index expected none, actual %0d",
                 out_enc_i);
        end else begin
          enc = enc_expected_q.pop_front();
          results++;
          if (out_enc_i !== enc) begin
            errors++;
            $error("encoding_index mismatch: expected %0d, actual %0d", enc, out_enc_i);
          end
        end
      end
      error_count_o <= errors;
      pending_o     <= enc_expected_q.size();
      results_o     <= results;
      enc_hit_o     <= hits;
    end
  end

endmodule

@@ verif/text_encoding_detector_tb.sv @@
`timescale 1ns / 1ps
// Top of the text encoding detector testbench: clock, reset, byte stream stimulus,
// result back-pressure and the verdict. Depends on ted_pkg, ted_in_if, ted_out_if,
// text_encoding_detector and ted_stream_checker.
module text_encoding_detector_tb;

  localparam int ItemCount    = 1900;
  localparam int CalmFrom     = 1650;
  localparam int RxHoldAt     = 600;
  localparam int DrainAt      = 1200;
  localparam int RxHoldCycles = 300;
  localparam int CycleLimit   = 400000;

  logic clk_i = 1'b0;
  logic rst_ni;

  ted_in_if  in_ch ();
  ted_out_if out_ch ();

  text_encoding_detector uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  int         error_count;
  int         pending;
  int         results;
  logic [7:0] enc_hit;

  ted_stream_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_ch.valid),
    .in_ready_i    (in_ch.ready),
    .in_byte_i     (in_ch.data_byte),
    .in_last_i     (in_ch.last_byte),
    .out_valid_i   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .out_enc_i     (out_ch.encoding_index),
    .error_count_o (error_count),
    .pending_o     (pending),
    .results_o     (results),
    .enc_hit_o     (enc_hit)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic       calm = 1'b0;
  logic       rx_hold_req = 1'b0;
  int         byte_count = 0;
  int         stream_count = 0;
  int         cycles = 0;
  logic [7:0] stream_q[$];

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random ready bursts, plus one long hold on request
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    if ($urandom_range(0, 7) != 0) begin
      c = 8'($urandom_range(8'h20, 8'h7e));
    end else begin
      case ($urandom_range(0, 7))
        0:       c = 8'h07;
        1:       c = 8'h08;
        2:       c = 8'h09;
        3:       c = 8'h0a;
        4:       c = 8'h0c;
        5:       c = 8'h0d;
        6:       c = 8'h1b;
        default: c = 8'h85;
      endcase
    end
    return c;
  endfunction

  function automatic logic [7:0] lead_byte(input int follow);
    logic [7:0] b;
    case (follow)
      1:       b = {3'b110, 5'($urandom())};
      2:       b = {4'b1110, 4'($urandom())};
      3:       b = {5'b11110, 3'($urandom())};
      4:       b = {6'b111110, 2'($urandom())};
      default: b = {7'b1111110, 1'($urandom())};
    endcase
    return b;
  endfunction

  task automatic build_stream();
    int          n;
    int          pick;
    int          follow;
    int          floor_b;
    int          i;
    logic        be;
    logic [15:0] unit;
    stream_q.delete();
    n    = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 48) : $urandom_range(1, 8);
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      repeat (n) stream_q.push_back(text_char());
    end else if (pick < 45) begin
      if ($urandom_range(0, 1) == 0) begin
        stream_q.push_back(ted_pkg::Bom8Byte0);
        stream_q.push_back(ted_pkg::Bom8Byte1);
        stream_q.push_back(ted_pkg::Bom8Byte2);
      end
      repeat (n) begin
        if ($urandom_range(0, 1) == 0) begin
          stream_q.push_back(text_char());
        end else begin
          follow = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 5) : $urandom_range(1, 3);
          stream_q.push_back(lead_byte(follow));
          repeat (follow) stream_q.push_back({2'b10, 6'($urandom())});
        end
      end
      // sequence cut short at the end of the stream
      if ($urandom_range(0, 5) == 0) stream_q.push_back(lead_byte($urandom_range(2, 5)));
    end else if (pick < 70) begin
      be = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) != 0) begin
        stream_q.push_back(be ? ted_pkg::Bom16Fe : ted_pkg::Bom16Ff);
        stream_q.push_back(be ? ted_pkg::Bom16Ff : ted_pkg::Bom16Fe);
      end
      repeat (n) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: unit = {8'h00, text_char()};
          5:             unit = {8'h00, 8'($urandom_range(0, 127))};
          6:             unit = 16'hfffe;
          default:       unit = 16'($urandom());
        endcase
        stream_q.push_back(be ? unit[15:8] : unit[7:0]);
        stream_q.push_back(be ? unit[7:0] : unit[15:8]);
      end
      if ($urandom_range(0, 7) == 0) void'(stream_q.pop_back());
    end else if (pick < 85) begin
      floor_b = ($urandom_range(0, 1) == 0) ? 8'ha0 : 8'h80;
      repeat (n) begin
        if ($urandom_range(0, 2) == 0) stream_q.push_back(text_char());
        else stream_q.push_back(8'($urandom_range(floor_b, 255)));
      end
    end else begin
      repeat (n) stream_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 7) == 0) begin
      i = $urandom_range(0, stream_q.size() - 1);
      stream_q[i] = 8'($urandom_range(0, 255));
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!calm && $urandom_range(0, 11) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    byte_count++;
  endtask

  task automatic send_stream();
    int i;
    for (i = 0; i < stream_q.size(); i++) send_byte(stream_q[i], i == stream_q.size() - 1);
    stream_count++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    logic hold_done;
    logic drain_done;
    hold_done       = 1'b0;
    drain_done      = 1'b0;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: single bytes at the extremes, both BOM flavors, short and odd streams
    stream_q = '{8'h00};                                     send_stream();
    stream_q = '{8'hff};                                     send_stream();
    stream_q = '{8'h41};                                     send_stream();
    stream_q = '{ted_pkg::Bom8Byte0, ted_pkg::Bom8Byte1, ted_pkg::Bom8Byte2,
                 8'hc3, 8'ha9};
    send_stream();
    stream_q = '{8'hc3, 8'ha9, 8'he2};                       send_stream();
    stream_q = '{ted_pkg::Bom16Fe, ted_pkg::Bom16Ff, 8'h00, 8'h41}; send_stream();
    stream_q = '{ted_pkg::Bom16Ff, ted_pkg::Bom16Fe, 8'h41, 8'h00}; send_stream();
    stream_q = '{ted_pkg::Bom16Fe, ted_pkg::Bom16Ff, 8'h00};        send_stream();
    stream_q = '{ted_pkg::Bom8Byte0, ted_pkg::Bom8Byte1};           send_stream();
    stream_q = '{8'h80};                                     send_stream();
    drain_results();

    while (byte_count < ItemCount) begin
      if (!hold_done && byte_count >= RxHoldAt) begin
        rx_hold_req = 1'b1;
        hold_done   = 1'b1;
      end
      if (!drain_done && byte_count >= DrainAt) begin
        drain_results();
        drain_done = 1'b1;
      end
      if (byte_count >= CalmFrom) calm = 1'b1;
      build_stream();
      send_stream();
    end

    drain_results();
    repeat (10) @(posedge clk_i);

    $display("Run covered %0d streams (%0d bytes), %0d results compared, one long result hold",
             stream_count, byte_count, results);
    $display("Encoding indexes predicted (bit per index, 7 down to 0): %b", enc_hit);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ text_encoding_detector.f @@
rtl/core/ted_pkg.sv
rtl/core/ted_in_if.sv
rtl/core/ted_out_if.sv
rtl/core/ted_byte_eval.sv
rtl/core/text_encoding_detector.sv
verif/ted_stream_checker.sv
verif/text_encoding_detector_tb.sv
